@@ hdl/cmst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmst_pkg: shared types and constants of the context score table
// Operation codes, lane command word and Q16.16 limits.
// ----------------------------------------------------------------------------
package cmst_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SCORE_W  = 36;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned ROW_IN_W = 6;
  localparam int unsigned OP_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ACC   = 2'd0,
    OP_EVAL  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_e;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic  clr;
    logic  acc;
    logic  wr;
    data_t weight;
    data_t value;
  } lane_cmd_t;

  localparam data_t Q_MAX = data_t'(32'h7FFF_FFFF);
  localparam data_t Q_MIN = data_t'(32'h8000_0000);

endpackage

@@ hdl/context_markov_score_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// context_markov_score_table: variable-order k-mer context score table
// One Q16.16 entry per context position and sub-context row.
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid_i / in_stall_o) takes one command word: accumulate,
//   evaluate, read entry or write entry. out channel (out_valid_o /
//   out_stall_i) returns exactly one result word per command.
//   each position has its own lane memory, so all positions are read at the
//   accept edge, updated or summed in the next cycle, and the lane sums are
//   merged in the one after; the result register loads from the merge step
//   once the output is free, and only then is a new word taken.
//   after reset the block sweeps all 4^(ORDER_MAX+1) rows of every lane
//   memory (64 at the defaults) to zero, one row per cycle, in_stall_o high.
//   a result waiting under out_stall_i does not block the next word from
//   being accepted; that word stalls in its merge step until the output
//   register frees up, and in_stall_o stays high meanwhile.
// ----------------------------------------------------------------------------
module context_markov_score_table #(
  parameter int unsigned CONTEXT_LEN = 9,
  parameter int unsigned ORDER_MAX   = 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [cmst_pkg::OP_W-1:0]             in_op_i,
  input  logic [2*CONTEXT_LEN-1:0]              in_context_bases_i,
  input  logic                                  in_reverse_first_i,
  input  logic signed [cmst_pkg::DATA_W-1:0]    in_weight_i,
  input  logic [cmst_pkg::POS_W-1:0]            in_entry_position_i,
  input  logic [cmst_pkg::ROW_IN_W-1:0]         in_entry_row_i,
  input  logic signed [cmst_pkg::DATA_W-1:0]    in_entry_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [cmst_pkg::SCORE_W-1:0]   out_score_o,
  output logic signed [cmst_pkg::DATA_W-1:0]    out_entry_out_o,
  output logic                                  out_saturated_o
);
  import cmst_pkg::*;

  localparam int unsigned RowW  = 2 * (ORDER_MAX + 1);
  localparam int unsigned Rows  = 1 << RowW;
  localparam int unsigned LaneW = $clog2(CONTEXT_LEN);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_SUM  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [RowW-1:0] clr_cnt_q, clr_cnt_d;
  logic            out_valid_q, out_valid_d;

  logic [OP_W-1:0]  op_q;
  logic [POS_W-1:0] pos_q;
  logic             pos_ok_q, row_ok_q;
  data_t            weight_q, value_q;
  logic             sat_q;

  logic signed [SCORE_W-1:0] score_q;
  data_t                     entry_q;
  logic                      out_sat_q;

  logic                        accept;
  logic                        out_free;
  logic                        load_out;
  logic [2*CONTEXT_LEN-1:0]    ctx_rc, ctx_sel;
  logic [RowW+ROW_IN_W-1:0]    row_in_ext;
  logic [RowW-1:0]             row_in_addr;
  logic                        row_ok_d, pos_ok_d;
  logic [RowW-1:0]             rd_addr [CONTEXT_LEN];
  lane_cmd_t                   lane_cmd [CONTEXT_LEN];
  logic [CONTEXT_LEN-1:0][DATA_W-1:0] lane_data;
  logic [CONTEXT_LEN-1:0]      lane_sat;
  logic signed [SCORE_W-1:0]   merge_sum;
  data_t                       entry_sel;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = state_q != ST_IDLE;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == ST_SUM) && out_free;

  // reverse complement: base order flipped, each code inverted
  for (genvar k = 0; k < CONTEXT_LEN; k++) begin : g_rc
    assign ctx_rc[2*k +: 2] = ~in_context_bases_i[2*(CONTEXT_LEN-1-k) +: 2];
  end

  assign ctx_sel = ((in_op_i == OP_ACC) && in_reverse_first_i) ? ctx_rc
                                                                 : in_context_bases_i;

  assign row_in_ext  = {{RowW{1'b0}}, in_entry_row_i};
  assign row_in_addr = row_in_ext[RowW-1:0];
  assign row_ok_d    = row_in_ext < (RowW+ROW_IN_W)'(Rows);
  assign pos_ok_d    = {1'b0, in_entry_position_i} < (POS_W+1)'(CONTEXT_LEN);

  for (genvar i = 0; i < CONTEXT_LEN; i++) begin : g_lane
    localparam int unsigned Ord = (i < ORDER_MAX) ? i : ORDER_MAX;
    localparam int unsigned Wid = 2 * (Ord + 1);
    localparam int unsigned Sh  = 2 * (CONTEXT_LEN - 1 - i);

    logic [RowW-1:0] win;

    assign win        = RowW'(ctx_sel[Sh +: Wid]);
    assign rd_addr[i] = ((in_op_i == OP_ACC) || (in_op_i == OP_EVAL)) ? win : row_in_addr;

    assign lane_cmd[i] = '{
      clr:    state_q == ST_CLR,
      acc:    (state_q == ST_EXEC) && (op_q == OP_ACC),
      wr:     (state_q == ST_EXEC) && (op_q == OP_WRITE) && row_ok_q && pos_ok_q &&
              (pos_q == POS_W'(i)),
      weight: weight_q,
      value:  value_q
    };

    cmst_lane #(
      .ROW_W (RowW)
    ) u_lane (
      .clk_i      (clk_i),
      .rd_en_i    (accept),
      .rd_addr_i  (rd_addr[i]),
      .clr_addr_i (clr_cnt_q),
      .cmd_i      (lane_cmd[i]),
      .rd_data_o  (lane_data[i]),
      .sat_o      (lane_sat[i])
    );
  end

  cmst_merge #(
    .NUM_LANES (CONTEXT_LEN)
  ) u_merge (
    .clk_i       (clk_i),
    .load_i      (state_q == ST_EXEC),
    .lane_data_i (lane_data),
    .sum_o       (merge_sum)
  );

  assign entry_sel = (pos_ok_q && row_ok_q) ? data_t'(lane_data[pos_q[LaneW-1:0]]) : '0;

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_CLR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // command word capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= in_op_i;
      pos_q    <= in_entry_position_i;
      pos_ok_q <= pos_ok_d;
      row_ok_q <= row_ok_d;
      weight_q <= in_weight_i;
      value_q  <= in_entry_value_i;
    end
    if (state_q == ST_EXEC) begin
      sat_q <= (op_q == OP_ACC) && (|lane_sat);
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      score_q   <= (op_q == OP_EVAL) ? merge_sum : '0;
      entry_q   <= (op_q == OP_READ) ? entry_sel : '0;
      out_sat_q <= sat_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_score_o     = score_q;
  assign out_entry_out_o = entry_q;
  assign out_saturated_o = out_sat_q;

  a_rise_from_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_SUM)
    else $error("result word appeared outside the merge step");

  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == ST_EXEC)
    else $error("accepted word did not enter the update step");

  a_exec_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |=> state_q == ST_SUM)
    else $error("update step not followed by merge step");

  a_hold_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM && out_valid_q && out_stall_i) |=> state_q == ST_SUM)
    else $error("finished word left the merge step while output was blocked");

endmodule

@@ hdl/cmst_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmst_lane: one context position column
// Row memory with registered read and a saturating read-modify-write port.
// ----------------------------------------------------------------------------
module cmst_lane #(
  parameter int unsigned ROW_W = 6
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [ROW_W-1:0]    rd_addr_i,
  input  logic [ROW_W-1:0]    clr_addr_i,
  input  cmst_pkg::lane_cmd_t cmd_i,
  output cmst_pkg::data_t     rd_data_o,
  output logic                sat_o
);
  import cmst_pkg::*;

  localparam int unsigned Depth = 1 << ROW_W;

  data_t                 mem_q [Depth];
  data_t                 rd_data_q;
  logic [ROW_W-1:0]      addr_q;
  logic signed [DATA_W:0] sum;
  logic                  ovf;
  data_t                 new_val;

  always_comb begin
    sum = {rd_data_q[DATA_W-1], rd_data_q} + {cmd_i.weight[DATA_W-1], cmd_i.weight};
    ovf = sum[DATA_W] != sum[DATA_W-1];
    if (ovf) begin
      new_val = sum[DATA_W] ? Q_MIN : Q_MAX;
    end else begin
      new_val = sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
      addr_q    <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.clr) begin
      mem_q[clr_addr_i] <= '0;
    end else if (cmd_i.acc) begin
      mem_q[addr_q] <= new_val;
    end else if (cmd_i.wr) begin
      mem_q[addr_q] <= cmd_i.value;
    end
  end

  assign rd_data_o = rd_data_q;
  assign sat_o     = ovf;

endmodule

@@ hdl/cmst_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmst_merge: lane sum tree
// Registered groups of four lane values, then a final add of the groups.
// ----------------------------------------------------------------------------
module cmst_merge #(
  parameter int unsigned NUM_LANES = 9
) (
  input  logic                                          clk_i,
  input  logic                                          load_i,
  input  logic [NUM_LANES-1:0][cmst_pkg::DATA_W-1:0]    lane_data_i,
  output logic signed [cmst_pkg::SCORE_W-1:0]           sum_o
);
  import cmst_pkg::*;

  localparam int unsigned NumGrp = (NUM_LANES + 3) / 4;

  logic signed [SCORE_W-1:0] ext   [NumGrp*4];
  logic signed [SCORE_W-1:0] grp_d [NumGrp];
  logic signed [SCORE_W-1:0] grp_q [NumGrp];

  for (genvar j = 0; j < NumGrp * 4; j++) begin : g_ext
    if (j < NUM_LANES) begin : g_lane
      assign ext[j] = {{(SCORE_W-DATA_W){lane_data_i[j][DATA_W-1]}}, lane_data_i[j]};
    end else begin : g_pad
      assign ext[j] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      grp_d[g] = (ext[g*4] + ext[g*4+1]) + (ext[g*4+2] + ext[g*4+3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    sum_o = '0;
    for (int g = 0; g < NumGrp; g++) begin
      sum_o = sum_o + grp_q[g];
    end
  end

endmodule
